### sv/mcmq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multi-channel message queues.
// No dependencies; imported by every other file of the block.
package mcmq_pkg;

	localparam int NUM_CHANNELS_DEF = 256;
	localparam int QUEUE_DEPTH_DEF  = 64;
	localparam int MSG_WIDTH_DEF    = 64;

	// Fixed field widths of the stream payload
	localparam int IDW        = 9;
	localparam int MSG_PORT_W = 64;
	localparam int OPW        = 2;
	localparam int STW        = 3;
	localparam int TDATA_W    = 80;

	// Open flags are grouped in words for the two-level free search
	localparam int GW  = 32;
	localparam int GBW = $clog2(GW);

	typedef enum logic [OPW-1:0] {
		OP_CREATE,
		OP_SEND,
		OP_RECV,
		OP_CLOSE
	} op_t;

	typedef enum logic [STW-1:0] {
		ST_OK,
		ST_BAD,
		ST_FULL,
		ST_EMPTY,
		ST_NOFREE
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RDATA
	} state_t;

	typedef struct packed {
		logic accept;    // capture input beat, start pointer read
		logic exec;      // apply the operation, load result
		logic load_msg;  // load popped message into result
	} cmd_t;

	typedef struct packed {
		logic recv_ok;   // receive hit: store data follows next cycle
	} sts_t;

endpackage

### sv/multi_channel_message_queues.sv
`timescale 1ns / 1ps
// Accept captures the beat and reads its pointer entry; S_EXEC applies the operation and
// registers the result; a receive hit loads the message in S_RDATA. No new beat is taken
// until the last is done, set by the pointer RAM read-modify-write and the store read.
// Reset: open flags and control cleared at once, no clearing pass; pointers of a slot
// are zeroed by create. Depends on mcmq_pkg, mcmq_ctrl, mcmq_dp, mcmq_ram.
module multi_channel_message_queues import mcmq_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int MSG_WIDTH    = MSG_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // channel_id[8:0], message_in[72:9]
	input  logic [OPW-1:0]     s_tuser,  // opcode[1:0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // new_channel[8:0], message_out[72:9]
	output logic [STW-1:0]     m_tuser   // status[2:0]
);

	cmd_t                  cmd;
	sts_t                  sts;
	status_t               status;
	logic [IDW-1:0]        new_channel;
	logic [MSG_PORT_W-1:0] message_out;

	mcmq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	mcmq_dp #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MSG_WIDTH   (MSG_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (op_t'(s_tuser)),
		.channel_id (s_tdata[IDW-1:0]),
		.message_in (s_tdata[IDW +: MSG_PORT_W]),
		.status     (status),
		.new_channel(new_channel),
		.message_out(message_out)
	);

	assign m_tdata = {{(TDATA_W - IDW - MSG_PORT_W){1'b0}}, message_out, new_channel};
	assign m_tuser = status;

endmodule

### sv/mcmq_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on mcmq_pkg for default sizes.
module mcmq_ram import mcmq_pkg::*; #(
	parameter int WIDTH = MSG_WIDTH_DEF,
	parameter int DEPTH = NUM_CHANNELS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/mcmq_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM: input/output handshake and sequencing of the datapath.
// Depends on mcmq_pkg.
module mcmq_ctrl import mcmq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   out_free;
	logic   set_valid;

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (set_valid) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		set_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			// side effects wait until the result register can take the beat
			S_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					if (sts.recv_ok) begin
						state_d = S_RDATA;
					end else begin
						set_valid = 1'b1;
						state_d   = S_IDLE;
					end
				end
			end
			S_RDATA: begin
				if (out_free) begin
					cmd.load_msg = 1'b1;
					set_valid    = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;

endmodule

### sv/mcmq_dp.sv
`timescale 1ns / 1ps
// Datapath: open flags with free-slot search, pointer RAM, message store,
// result register. Depends on mcmq_pkg and mcmq_ram.
module mcmq_dp import mcmq_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int MSG_WIDTH    = MSG_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  op_t                   opcode,
	input  logic [IDW-1:0]        channel_id,
	input  logic [MSG_PORT_W-1:0] message_in,
	output status_t               status,
	output logic [IDW-1:0]        new_channel,
	output logic [MSG_PORT_W-1:0] message_out
);

	localparam int CH_W = $clog2(NUM_CHANNELS);
	localparam int NG   = (NUM_CHANNELS + GW - 1) / GW;
	localparam int GIW  = (NG > 1) ? $clog2(NG) : 1;
	localparam int FW   = GIW + GBW;
	localparam int PW   = $clog2(QUEUE_DEPTH);
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int SDEP = NUM_CHANNELS * (2 ** PW);

	typedef struct packed {
		logic [CW-1:0] cnt;
		logic [PW-1:0] wr;
		logic [PW-1:0] rd;
	} ptr_ent_t;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// flags for padding slots past NUM_CHANNELS stay set, so they never look free
	logic [NG*GW-1:0]     open_q;
	logic [NG-1:0]        grp_full_q;

	op_t                  op_q;
	logic [IDW-1:0]       id_q;
	logic [MSG_WIDTH-1:0] msg_q;
	logic [GIW-1:0]       grp_q;
	logic                 nofree_q;

	status_t              status_q;
	logic [IDW-1:0]       newch_q;
	logic [MSG_PORT_W-1:0] msg_out_q;

	logic [GIW-1:0]       grp_sel;
	logic [CH_W-1:0]      in_slot;
	logic [CH_W-1:0]      slot;
	logic [FW-1:0]        slot_f;
	logic                 id_ok;
	logic                 chan_ok;
	logic [GW-1:0]        grp_word;
	logic [GBW-1:0]       bit_sel;
	logic [FW-1:0]        new_slot_f;
	logic [CH_W-1:0]      new_slot;
	logic                 create_ok, send_ok, recv_ok, close_ok;
	status_t              res_status;
	logic [IDW-1:0]       res_newch;

	ptr_ent_t             ptr_rdata, ptr_wdata;
	logic                 ptr_we;
	logic [CH_W-1:0]      ptr_waddr;
	logic [MSG_WIDTH-1:0] store_rdata;

	// first group with a free slot, registered on the accepted beat
	always_comb begin
		grp_sel = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (!grp_full_q[g]) begin
				grp_sel = GIW'(g);
			end
		end
	end

	assign in_slot = CH_W'(32'(channel_id) - 32'd1);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= opcode;
			id_q     <= channel_id;
			msg_q    <= message_in[MSG_WIDTH-1:0];
			grp_q    <= grp_sel;
			nofree_q <= &grp_full_q;
		end
	end

	assign slot    = CH_W'(32'(id_q) - 32'd1);
	assign slot_f  = FW'(slot);
	assign id_ok   = (id_q != '0) && (32'(id_q) <= 32'(NUM_CHANNELS));
	assign chan_ok = id_ok && open_q[slot_f];

	// lowest free bit inside the chosen group
	assign grp_word = open_q[{grp_q, {GBW{1'b0}}} +: GW];

	always_comb begin
		bit_sel = '0;
		for (int i = GW - 1; i >= 0; i--) begin
			if (!grp_word[i]) begin
				bit_sel = GBW'(i);
			end
		end
	end

	assign new_slot_f = {grp_q, bit_sel};
	assign new_slot   = CH_W'(new_slot_f);

	always_comb begin
		create_ok  = 1'b0;
		send_ok    = 1'b0;
		recv_ok    = 1'b0;
		close_ok   = 1'b0;
		res_status = ST_OK;
		res_newch  = '0;
		case (op_q)
			OP_CREATE: begin
				if (nofree_q) begin
					res_status = ST_NOFREE;
				end else begin
					create_ok = 1'b1;
					res_newch = IDW'(32'(new_slot) + 32'd1);
				end
			end
			OP_SEND: begin
				if (!chan_ok) begin
					res_status = ST_BAD;
				end else if (ptr_rdata.cnt >= CW'(QUEUE_DEPTH)) begin
					res_status = ST_FULL;
				end else begin
					send_ok = 1'b1;
				end
			end
			OP_RECV: begin
				if (!chan_ok) begin
					res_status = ST_BAD;
				end else if (ptr_rdata.cnt == '0) begin
					res_status = ST_EMPTY;
				end else begin
					recv_ok = 1'b1;
				end
			end
			OP_CLOSE: begin
				if (!chan_ok) begin
					res_status = ST_BAD;
				end else begin
					close_ok = 1'b1;
				end
			end
			default: begin
				res_status = ST_BAD;
			end
		endcase
	end

	assign sts.recv_ok = recv_ok;

	// per-channel pointers: read on accept, written back on execute
	always_comb begin
		ptr_we    = cmd.exec && (create_ok || send_ok || recv_ok);
		ptr_waddr = create_ok ? new_slot : slot;
		ptr_wdata = ptr_rdata;
		if (create_ok) begin
			ptr_wdata = '0;
		end else if (send_ok) begin
			ptr_wdata.cnt = ptr_rdata.cnt + 1'b1;
			ptr_wdata.wr  = bump(ptr_rdata.wr);
		end else if (recv_ok) begin
			ptr_wdata.cnt = ptr_rdata.cnt - 1'b1;
			ptr_wdata.rd  = bump(ptr_rdata.rd);
		end
	end

	mcmq_ram #(
		.WIDTH($bits(ptr_ent_t)),
		.DEPTH(NUM_CHANNELS)
	) u_ptr_ram (
		.clk  (clk),
		.we   (ptr_we),
		.waddr(ptr_waddr),
		.wdata(ptr_wdata),
		.re   (cmd.accept),
		.raddr(in_slot),
		.rdata(ptr_rdata)
	);

	mcmq_ram #(
		.WIDTH(MSG_WIDTH),
		.DEPTH(SDEP)
	) u_store_ram (
		.clk  (clk),
		.we   (cmd.exec && send_ok),
		.waddr({slot, ptr_rdata.wr}),
		.wdata(msg_q),
		.re   (cmd.exec && recv_ok),
		.raddr({slot, ptr_rdata.rd}),
		.rdata(store_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NG * GW; b++) begin
				open_q[b] <= (b >= NUM_CHANNELS);
			end
			grp_full_q <= '0;
		end else if (cmd.exec) begin
			if (create_ok) begin
				open_q[new_slot_f] <= 1'b1;
				grp_full_q[grp_q]  <= &(grp_word | (GW'(1) << bit_sel));
			end
			if (close_ok) begin
				open_q[slot_f]               <= 1'b0;
				grp_full_q[slot_f[FW-1:GBW]] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q  <= res_status;
			newch_q   <= res_newch;
			msg_out_q <= '0;
		end else if (cmd.load_msg) begin
			msg_out_q <= MSG_PORT_W'(store_rdata);
		end
	end

	assign status      = status_q;
	assign new_channel = newch_q;
	assign message_out = msg_out_q;

`ifndef SYNTHESIS
	a_create_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && create_ok) |-> !open_q[new_slot_f])
		else $error("create picked an open slot");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_we |-> (ptr_wdata.cnt <= CW'(QUEUE_DEPTH)))
		else $error("queue count beyond depth");

	a_recv_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && recv_ok) |=> !cmd.exec)
		else $error("execute issued while store read pending");
`endif

endmodule

### tb/mcmq_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the multi-channel message queues: watches both stream ports,
// keeps its own copy of the queue bank and checks every result beat.
// Depends on mcmq_pkg.
module mcmq_checker import mcmq_pkg::*; #(
	parameter int NCH   = NUM_CHANNELS_DEF,
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	parameter int MW    = MSG_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,
	input  logic [OPW-1:0]     s_tuser,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,
	input  logic [STW-1:0]     m_tuser,
	output int                 fail_count,
	output int                 pending
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef struct packed {
		status_t                status;
		logic [IDW-1:0]         new_ch;
		logic [MSG_PORT_W-1:0]  msg;
	} reply_t;

	reply_t replies_due[$];
	int errors;

	logic          chan_open[NCH];
	logic [PW-1:0] rd_ptr[NCH];
	logic [PW-1:0] wr_ptr[NCH];
	logic [CW-1:0] fill_cnt[NCH];
	logic [MW-1:0] msg_ram[NCH][DEPTH];

	function automatic logic [PW-1:0] ring_next(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Applies one request to the queue bank and returns the reply it must produce
	function automatic reply_t serve_request(op_t op, logic [IDW-1:0] id,
			logic [MSG_PORT_W-1:0] msg_in);
		reply_t r;
		int slot;
		logic found;
		r.status = ST_OK;
		r.new_ch = '0;
		r.msg = '0;
		found = 1'b0;
		if (op == OP_CREATE) begin
			r.status = ST_NOFREE;
			for (int i = 0; i < NCH && !found; i++)
				if (!chan_open[i]) begin
					found = 1'b1;
					chan_open[i] = 1'b1;
					rd_ptr[i] = '0;
					wr_ptr[i] = '0;
					fill_cnt[i] = '0;
					r.new_ch = IDW'(i + 1);
					r.status = ST_OK;
				end
		end else if (id == '0 || int'(id) > NCH) begin
			r.status = ST_BAD;
		end else begin
			slot = int'(id) - 1;
			if (!chan_open[slot]) begin
				r.status = ST_BAD;
			end else begin
				case (op)
					OP_SEND: begin
						if (fill_cnt[slot] == CW'(DEPTH)) begin
							r.status = ST_FULL;
						end else begin
							msg_ram[slot][wr_ptr[slot]] = msg_in[MW-1:0];
							wr_ptr[slot] = ring_next(wr_ptr[slot]);
							fill_cnt[slot] = fill_cnt[slot] + 1'b1;
						end
					end
					OP_RECV: begin
						if (fill_cnt[slot] == '0) begin
							r.status = ST_EMPTY;
						end else begin
							r.msg = MSG_PORT_W'(msg_ram[slot][rd_ptr[slot]]);
							rd_ptr[slot] = ring_next(rd_ptr[slot]);
							fill_cnt[slot] = fill_cnt[slot] - 1'b1;
						end
					end
					default: chan_open[slot] = 1'b0;
				endcase
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			replies_due.delete();
			errors = 0;
			for (int i = 0; i < NCH; i++) begin
				chan_open[i] = 1'b0;
				rd_ptr[i] = '0;
				wr_ptr[i] = '0;
				fill_cnt[i] = '0;
			end
			fail_count <= 0;
			pending <= 0;
		end else begin
			// result side first: a reply never leaves in the beat its request arrives
			if (m_tvalid && m_tready) begin
				if (replies_due.size() == 0) begin
					$error("result beat with no request outstanding");
					errors++;
				end else begin
					want = replies_due.pop_front();
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_tuser);
						errors++;
					end
					if (m_tdata[IDW-1:0] !== want.new_ch) begin
						$error("new_channel: expected %0d, actual %0d", want.new_ch,
							m_tdata[IDW-1:0]);
						errors++;
					end
					if (m_tdata[IDW +: MSG_PORT_W] !== want.msg) begin
						$error("message_out: expected %h, actual %h", want.msg,
							m_tdata[IDW +: MSG_PORT_W]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				replies_due.push_back(serve_request(op_t'(s_tuser), s_tdata[IDW-1:0],
					s_tdata[IDW +: MSG_PORT_W]));
			fail_count <= errors;
			pending <= replies_due.size();
		end
	end

endmodule

### tb/tb_multi_channel_message_queues.sv
`timescale 1ns / 1ps
// Top of the message queue testbench: clock, reset, request and result stimulus.
// Depends on mcmq_pkg, mcmq_checker and the multi_channel_message_queues RTL.
module tb_multi_channel_message_queues;
	import mcmq_pkg::*;

	localparam int NCH       = NUM_CHANNELS_DEF;
	localparam int DEPTH     = QUEUE_DEPTH_DEF;
	localparam int N_ITEMS   = 1150;
	localparam int MAX_CYCLES = 500000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;  // channel_id[8:0], message_in[72:9]
	logic [OPW-1:0]     s_tuser;  // opcode[1:0]
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;  // new_channel[8:0], message_out[72:9]
	logic [STW-1:0]     m_tuser;  // status[2:0]

	int fail_count;
	int pending;
	int cycle_count = 0;
	int n_issued = 0;
	int send_burst = 0;
	int recv_burst = 0;

	// stimulus-side bookkeeping, used only to aim requests at live channels
	logic chan_live[NCH];
	int   chan_fill[NCH];

	always #5 clk = ~clk;

	multi_channel_message_queues DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	mcmq_checker #(.NCH(NCH), .DEPTH(DEPTH), .MW(MSG_WIDTH_DEF)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= MAX_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// random idle gap per beat, with occasional runs of back-to-back beats
	function automatic int draw_gap(ref int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			stall = draw_gap(recv_burst);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic issue_request(op_t op, logic [IDW-1:0] id, logic [MSG_PORT_W-1:0] msg);
		int gap;
		logic found;
		int slot;
		found = 1'b0;
		if (op == OP_CREATE) begin
			for (int i = 0; i < NCH && !found; i++)
				if (!chan_live[i]) begin
					found = 1'b1;
					chan_live[i] = 1'b1;
					chan_fill[i] = 0;
				end
		end else if (id != '0 && int'(id) <= NCH && chan_live[int'(id) - 1]) begin
			slot = int'(id) - 1;
			case (op)
				OP_SEND:  if (chan_fill[slot] < DEPTH) chan_fill[slot]++;
				OP_RECV:  if (chan_fill[slot] > 0) chan_fill[slot]--;
				default:  chan_live[slot] = 1'b0;
			endcase
		end
		gap = draw_gap(send_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= TDATA_W'({msg, id});
		do @(posedge clk); while (!s_tready);
		n_issued++;
	endtask

	function automatic logic [MSG_PORT_W-1:0] random_msg();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic random_request(int create_w, int send_w, int recv_w);
		int pick;
		int r;
		int live[$];
		op_t op;
		logic [IDW-1:0] id;
		for (int i = 0; i < NCH; i++)
			if (chan_live[i]) live.push_back(i);
		pick = $urandom_range(0, 99);
		if (pick < create_w) op = OP_CREATE;
		else if (pick < create_w + send_w) op = OP_SEND;
		else if (pick < create_w + send_w + recv_w) op = OP_RECV;
		else op = OP_CLOSE;
		r = $urandom_range(0, 99);
		// mostly the lowest live channel, so a queue gets deep enough to fill
		if (r < 80 && live.size() > 0)
			id = (r < 50) ? IDW'(live[0] + 1) : IDW'(live[$urandom_range(0, live.size() - 1)] + 1);
		else if (r < 90)
			id = IDW'($urandom_range(0, (1 << IDW) - 1));
		else
			id = IDW'($urandom_range(1, NCH));
		issue_request(op, id, random_msg());
	endtask

	initial begin
		int live_cnt;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_CREATE;
		for (int i = 0; i < NCH; i++) begin
			chan_live[i] = 1'b0;
			chan_fill[i] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every opcode, payload extremes, bad ids, inactive and reused slots
		issue_request(OP_CREATE, 9'd0, '0);
		issue_request(OP_SEND, 9'd1, '0);
		issue_request(OP_SEND, 9'd1, '1);
		issue_request(OP_SEND, 9'd1, 64'hA5A5_5A5A_0F0F_F0F0);
		issue_request(OP_RECV, 9'd1, '1);
		issue_request(OP_RECV, 9'd1, '0);
		issue_request(OP_RECV, 9'd1, '0);
		issue_request(OP_RECV, 9'd1, '0);
		issue_request(OP_SEND, 9'd0, '1);
		issue_request(OP_RECV, 9'd257, '0);
		issue_request(OP_CLOSE, 9'd511, '0);
		issue_request(OP_SEND, 9'd200, 64'h1234);
		issue_request(OP_RECV, 9'd200, '0);
		issue_request(OP_CLOSE, 9'd200, '0);
		issue_request(OP_CREATE, 9'd511, '1);
		issue_request(OP_SEND, 9'd2, 64'hDEAD_BEEF_CAFE_F00D);
		issue_request(OP_SEND, 9'd1, 64'h55);
		issue_request(OP_CLOSE, 9'd1, '0);
		issue_request(OP_SEND, 9'd1, 64'h66);
		issue_request(OP_CREATE, 9'd0, '0);
		// reopened slot starts empty even though old data is still stored
		issue_request(OP_RECV, 9'd1, '0);
		issue_request(OP_CREATE, 9'd256, '0);
		issue_request(OP_RECV, 9'd2, '0);
		issue_request(OP_CLOSE, 9'd3, '0);

		// mixed traffic, alternating send-heavy and receive-heavy stretches
		for (int b = 0; b < 4; b++)
			for (int k = 0; k < 60; k++)
				if (b % 2 == 0) random_request(8, 62, 20);
				else random_request(8, 20, 62);

		// open every slot, then ask for more than exist
		do begin
			live_cnt = 0;
			for (int i = 0; i < NCH; i++)
				if (chan_live[i]) live_cnt++;
			issue_request(OP_CREATE, IDW'($urandom_range(0, (1 << IDW) - 1)), random_msg());
		end while (live_cnt < NCH);
		issue_request(OP_CREATE, 9'd0, '0);

		// last slot: drain, partial fill, partial drain, refill across the wrap to full, drain to empty
		while (chan_fill[NCH - 1] > 0)
			issue_request(OP_RECV, IDW'(NCH), '0);
		for (int k = 0; k < 40; k++) issue_request(OP_SEND, IDW'(NCH), random_msg());
		for (int k = 0; k < 30; k++) issue_request(OP_RECV, IDW'(NCH), '0);
		for (int k = 0; k < 60; k++) issue_request(OP_SEND, IDW'(NCH), random_msg());
		for (int k = 0; k < 70; k++) issue_request(OP_RECV, IDW'(NCH), '0);

		// churn: closes free slots that creates then refill lowest first
		while (n_issued < N_ITEMS) random_request(15, 35, 30);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
